// ----- rtl/core/crc16_frame_receiver_top_macros.svh -----
`ifndef CRC16_FRAME_RECEIVER_TOP_MACROS_SVH
`define CRC16_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CRC16FR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRC16FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/crc16fr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crc16fr_pkg;

  // Frame decoder phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_LO  = 3'd5,
    PH_CRC_HI  = 3'd6
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_LEN_ERR = 2'd2,
    KIND_CRC_ERR = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_BYTE  = 2'd0,
    REG_MAX_PAYLOAD = 2'd1
  } reg_idx_t;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // One result from the parser to the output stage
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  command;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [15:0] frame_len;
  } result_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crc16_frame_receiver_top.sv -----
// Frame receiver: start byte, command, 16-bit little-endian length, payload and
// a little-endian CRC-16/CCITT-FALSE over command, length and payload.
// Input channel: one received byte per transaction (in_valid / in_ready).
// Output channel: payload bytes as they arrive (kind 0), then one verdict per
// frame: good, length error (as soon as the length exceeds the limit) or CRC
// error. Payload bytes precede their verdict; discard them on an error.
// Configuration: cfg_we writes start_byte (index 0) or max_payload (index 1);
// write only while idle. The effective length limit is the smaller of
// max_payload and MAX_PAYLOAD.
// Throughput: one byte per cycle while the output register is empty or taken;
// the CRC update of one byte is a single combinational step on the CRC register.
// A result is registered and is on out_* in the cycle after its byte is accepted.
// When the receiver stalls the result is held and in_ready stays high as long
// as the output register is empty or being taken in the same cycle.
// Reset: hunting for the start byte, start_byte = 0xA5, max_payload = 1024,
// output empty.
`timescale 1ns / 1ps
`default_nettype none

`include "crc16_frame_receiver_top_macros.svh"

module crc16_frame_receiver_top #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_command,
  output logic [7:0]       out_data_byte,
  output logic [9:0]       out_byte_index,
  output logic [15:0]      out_frame_len,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  localparam logic [15:0] MaxLimit = 16'(MAX_PAYLOAD);

  logic [7:0]  start_byte_r;
  logic [10:0] max_payload_r;
  logic [10:0] limit;
  logic        in_fire;
  logic        out_valid_r, out_valid_nxt;
  crc16fr_pkg::result_t res;
  crc16fr_pkg::result_t out_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= 8'd165;
      max_payload_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        crc16fr_pkg::REG_START_BYTE:  start_byte_r  <= cfg_wdata[7:0];
        crc16fr_pkg::REG_MAX_PAYLOAD: max_payload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the length limit to the build-time maximum
  assign limit = ({5'd0, max_payload_r} < MaxLimit) ? max_payload_r : MaxLimit[10:0];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  crc16fr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .byte_in    (in_byte_in),
    .start_byte (start_byte_r),
    .limit      (limit),
    .res        (res)
  );

  // Drain the result register, then load a new result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && res.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_command    = out_r.command;
  assign out_data_byte  = out_r.data_byte;
  assign out_byte_index = out_r.byte_index;
  assign out_frame_len  = out_r.frame_len;

  // Checks
  `CRC16FR_ASSERT_NEXT(a_result_loads, in_fire && res.valid, out_valid_r, "result not registered")
  `CRC16FR_ASSERT_NOW(a_index_in_len, out_valid_r && out_r.kind == crc16fr_pkg::KIND_DATA, 16'(out_r.byte_index) < out_r.frame_len, "index past length")
  `CRC16FR_ASSERT_NOW(a_verdict_clean, out_valid_r && out_r.kind != crc16fr_pkg::KIND_DATA, out_r.data_byte == 8'd0 && out_r.byte_index == 10'd0, "verdict carries data")

endmodule

`default_nettype wire

// ----- rtl/core/crc16fr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crc16fr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           byte_in,
  input  wire logic [7:0]           start_byte,
  input  wire logic [10:0]          limit,
  output crc16fr_pkg::result_t      res
);

  crc16fr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [10:0] cnt_inc;

  assign crc_upd  = crc16fr_pkg::crc_update(crc_r, byte_in);
  assign len_full = {byte_in, len_r[7:0]};
  assign cnt_inc  = cnt_r + 11'd1;

  // Hold state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= crc16fr_pkg::PH_HUNT;
      crc_r    <= crc16fr_pkg::CrcInit;
      cmd_r    <= 8'h00;
      len_r    <= 16'h0000;
      cnt_r    <= 11'd0;
      crc_lo_r <= 8'h00;
    end else if (step) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Next state and result for the incoming byte
  always_comb begin
    phase_nxt      = phase_r;
    crc_nxt        = crc_r;
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    crc_lo_nxt     = crc_lo_r;
    res.valid      = 1'b0;
    res.kind       = crc16fr_pkg::KIND_DATA;
    res.command    = cmd_r;
    res.data_byte  = 8'h00;
    res.byte_index = 10'd0;
    res.frame_len  = len_r;
    case (phase_r)
      crc16fr_pkg::PH_HUNT: begin
        if (byte_in == start_byte) begin
          crc_nxt   = crc16fr_pkg::CrcInit;
          phase_nxt = crc16fr_pkg::PH_CMD;
        end
      end
      crc16fr_pkg::PH_CMD: begin
        cmd_nxt   = byte_in;
        crc_nxt   = crc_upd;
        phase_nxt = crc16fr_pkg::PH_LEN_LO;
      end
      crc16fr_pkg::PH_LEN_LO: begin
        len_nxt   = {8'h00, byte_in};
        crc_nxt   = crc_upd;
        phase_nxt = crc16fr_pkg::PH_LEN_HI;
      end
      crc16fr_pkg::PH_LEN_HI: begin
        len_nxt = len_full;
        crc_nxt = crc_upd;
        cnt_nxt = 11'd0;
        if (len_full > {5'd0, limit}) begin
          // Oversized frame: flag it and go back to hunting
          res.valid     = 1'b1;
          res.kind      = crc16fr_pkg::KIND_LEN_ERR;
          res.frame_len = len_full;
          crc_nxt       = crc16fr_pkg::CrcInit;
          phase_nxt     = crc16fr_pkg::PH_HUNT;
        end else if (len_full == 16'd0) begin
          phase_nxt = crc16fr_pkg::PH_CRC_LO;
        end else begin
          phase_nxt = crc16fr_pkg::PH_PAYLOAD;
        end
      end
      crc16fr_pkg::PH_PAYLOAD: begin
        crc_nxt        = crc_upd;
        res.valid      = 1'b1;
        res.data_byte  = byte_in;
        res.byte_index = cnt_r[9:0];
        cnt_nxt        = cnt_inc;
        if ({5'd0, cnt_inc} >= len_r) begin
          phase_nxt = crc16fr_pkg::PH_CRC_LO;
        end
      end
      crc16fr_pkg::PH_CRC_LO: begin
        crc_lo_nxt = byte_in;
        phase_nxt  = crc16fr_pkg::PH_CRC_HI;
      end
      crc16fr_pkg::PH_CRC_HI: begin
        res.valid = 1'b1;
        res.kind  = ({byte_in, crc_lo_r} == crc_r) ? crc16fr_pkg::KIND_GOOD
                                                   : crc16fr_pkg::KIND_CRC_ERR;
        crc_nxt   = crc16fr_pkg::CrcInit;
        phase_nxt = crc16fr_pkg::PH_HUNT;
      end
      default: begin
        crc_nxt   = crc16fr_pkg::CrcInit;
        phase_nxt = crc16fr_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire
